[rtl/core/srec_pkg.sv]
`timescale 1ns / 1ps

package srec_pkg;

  // default number of data bytes in a full S1 record
  localparam int unsigned RecordDataBytesDefault = 32;

  // bytes besides the data in the count: address high, address low, checksum
  localparam logic [7:0] RecOverhead = 8'd3;

  // count byte of an S9 end record
  localparam logic [7:0] EndCount = 8'd3;

  // input item actions
  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_WORD  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_END   = 2'd3
  } action_e;

  // output record kinds
  typedef enum logic {
    KIND_S1 = 1'b0,
    KIND_S9 = 1'b1
  } kind_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_LO,
    ST_ADD_HI,
    ST_REC_COUNT,
    ST_REC_ADDR_HI,
    ST_REC_ADDR_LO,
    ST_REC_DATA,
    ST_REC_SUM,
    ST_END_COUNT,
    ST_END_HI,
    ST_END_LO,
    ST_END_SUM
  } state_e;

endpackage

[rtl/core/srecord_s1_record_builder_unit.sv]
`timescale 1ns / 1ps

// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+--------------------------------------
// input     | in        | in_valid_i / in_ready_o      | action_i, data_value_i, location_i
// output    | out       | out_valid_o / out_ready_i    | record_kind_o, out_byte_o, last_o
// config    | in        | cfg_we_i (no wait)           | cfg_wdata_i (start_address)
//
// a byte item is accepted, then makes one pass through the shared adder, a word item two;
// an item that closes a record then sends its count, address, data and checksum bytes, an end
// item an S9 record; the single output register passes one record byte a cycle when not stalled.
// an output stall holds the sequencer in its current byte; the last byte of an item may wait
// in the output register while the next item is taken.
// reset is asynchronous, active low, and needs no clearing pass; the data buffer is only
// read at entries written in the open record.

module srecord_s1_record_builder_unit #(
  parameter int unsigned RECORD_DATA_BYTES = srec_pkg::RecordDataBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] data_value_i,
  input  logic [15:0] location_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        record_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  import srec_pkg::*;

  localparam int unsigned FillW = $clog2(RECORD_DATA_BYTES + 1);
  localparam int unsigned IdxW  = (RECORD_DATA_BYTES > 1) ? $clog2(RECORD_DATA_BYTES) : 1;
  localparam logic [FillW-1:0] FillMax = FillW'(RECORD_DATA_BYTES);

  // state and registers
  state_e            state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  idx_q, idx_d;
  logic [15:0]       base_q, base_d;
  logic [7:0]        sum_q, sum_d;
  logic [15:0]       start_q;
  logic              hi_pending_q, hi_pending_d;
  action_e           act_q;
  logic [15:0]       value_q;
  logic [15:0]       loc_q;
  logic              out_valid_q;
  logic              out_kind_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic [7:0]        rd_data_q;
  logic [7:0]        mem_q [RECORD_DATA_BYTES];

  // datapath signals
  logic              in_xfer;
  logic              slot_free;
  logic              do_add;
  logic [7:0]        add_byte;
  logic [15:0]       add_loc;
  logic [FillW-1:0]  fill_inc;
  logic              rec_full;
  logic [FillW-1:0]  idx_inc;
  logic              data_done;
  logic [7:0]        count_byte;
  logic [15:0]       pair_src;
  logic [7:0]        pair_sum;
  logic [7:0]        add_a, add_b, add_y;
  logic              mem_we;
  logic              load_out;
  logic              nxt_kind;
  logic [7:0]        nxt_byte;
  logic              nxt_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_q | out_ready_i;

  // byte and location of the add step
  assign do_add     = (state_q == ST_ADD_LO) || (state_q == ST_ADD_HI);
  assign add_byte   = (state_q == ST_ADD_HI) ? value_q[15:8] : value_q[7:0];
  assign add_loc    = (state_q == ST_ADD_HI) ? (loc_q + 16'd1) : loc_q;
  assign fill_inc   = fill_q + FillW'(1);
  assign rec_full   = (fill_inc == FillMax);
  assign idx_inc    = idx_q + FillW'(1);
  assign data_done  = (idx_inc == fill_q);
  assign count_byte = 8'(fill_q) + RecOverhead;

  // shared adder: running sum on adds, checksum on the last byte of a record
  assign pair_src = (state_q == ST_END_SUM) ? start_q : add_loc;
  assign pair_sum = pair_src[15:8] + pair_src[7:0];

  always_comb begin
    unique case (state_q)
      ST_REC_SUM: begin
        add_a = sum_q;
        add_b = count_byte;
      end
      ST_END_SUM: begin
        add_a = pair_sum;
        add_b = EndCount;
      end
      default: begin
        add_a = (fill_q == '0) ? pair_sum : sum_q;
        add_b = add_byte;
      end
    endcase
  end

  assign add_y = add_a + add_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (action_e'(action_i))
            ACT_BYTE, ACT_WORD: state_d = ST_ADD_LO;
            ACT_FLUSH:          state_d = (fill_q != '0) ? ST_REC_COUNT : ST_IDLE;
            ACT_END:            state_d = ST_END_COUNT;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_LO: begin
        if (rec_full) begin
          state_d = ST_REC_COUNT;
        end else if (act_q == ACT_WORD) begin
          state_d = ST_ADD_HI;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ADD_HI: begin
        state_d = rec_full ? ST_REC_COUNT : ST_IDLE;
      end
      ST_REC_COUNT:   if (slot_free) state_d = ST_REC_ADDR_HI;
      ST_REC_ADDR_HI: if (slot_free) state_d = ST_REC_ADDR_LO;
      ST_REC_ADDR_LO: if (slot_free) state_d = ST_REC_DATA;
      ST_REC_DATA:    if (slot_free && data_done) state_d = ST_REC_SUM;
      ST_REC_SUM: begin
        if (slot_free) state_d = hi_pending_q ? ST_ADD_HI : ST_IDLE;
      end
      ST_END_COUNT:   if (slot_free) state_d = ST_END_HI;
      ST_END_HI:      if (slot_free) state_d = ST_END_LO;
      ST_END_LO:      if (slot_free) state_d = ST_END_SUM;
      ST_END_SUM:     if (slot_free) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    fill_d       = fill_q;
    idx_d        = idx_q;
    base_d       = base_q;
    sum_d        = sum_q;
    hi_pending_d = hi_pending_q;
    mem_we       = 1'b0;
    load_out     = 1'b0;
    nxt_kind     = KIND_S1;
    nxt_byte     = count_byte;
    nxt_last     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) hi_pending_d = (action_e'(action_i) == ACT_WORD);
      end
      ST_ADD_LO, ST_ADD_HI: begin
        mem_we = 1'b1;
        fill_d = fill_inc;
        sum_d  = add_y;
        if (fill_q == '0) base_d = add_loc;
        if (state_q == ST_ADD_HI) hi_pending_d = 1'b0;
      end
      ST_REC_COUNT: begin
        load_out = slot_free;
        nxt_byte = count_byte;
        if (slot_free) idx_d = '0;
      end
      ST_REC_ADDR_HI: begin
        load_out = slot_free;
        nxt_byte = base_q[15:8];
      end
      ST_REC_ADDR_LO: begin
        load_out = slot_free;
        nxt_byte = base_q[7:0];
      end
      ST_REC_DATA: begin
        load_out = slot_free;
        nxt_byte = rd_data_q;
        if (slot_free) idx_d = idx_inc;
      end
      ST_REC_SUM: begin
        load_out = slot_free;
        nxt_byte = ~add_y;
        nxt_last = 1'b1;
        if (slot_free) begin
          fill_d = '0;
          sum_d  = '0;
        end
      end
      ST_END_COUNT: begin
        load_out = slot_free;
        nxt_kind = KIND_S9;
        nxt_byte = EndCount;
      end
      ST_END_HI: begin
        load_out = slot_free;
        nxt_kind = KIND_S9;
        nxt_byte = start_q[15:8];
      end
      ST_END_LO: begin
        load_out = slot_free;
        nxt_kind = KIND_S9;
        nxt_byte = start_q[7:0];
      end
      ST_END_SUM: begin
        load_out = slot_free;
        nxt_kind = KIND_S9;
        nxt_byte = ~add_y;
        nxt_last = 1'b1;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      idx_q        <= '0;
      base_q       <= '0;
      sum_q        <= '0;
      start_q      <= '0;
      hi_pending_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      idx_q        <= idx_d;
      base_q       <= base_d;
      sum_q        <= sum_d;
      hi_pending_q <= hi_pending_d;
      if (cfg_we_i) start_q <= cfg_wdata_i;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and output payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q   <= action_e'(action_i);
      value_q <= data_value_i;
      loc_q   <= location_i;
    end
    if (load_out) begin
      out_kind_q <= nxt_kind;
      out_byte_q <= nxt_byte;
      out_last_q <= nxt_last;
    end
  end

  // data buffer, read one entry ahead of the sequencer
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[fill_q[IdxW-1:0]] <= add_byte;
    rd_data_q <= mem_q[idx_d[IdxW-1:0]];
  end

  assign out_valid_o   = out_valid_q;
  assign record_kind_o = out_kind_q;
  assign out_byte_o    = out_byte_q;
  assign last_o        = out_last_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FillMax)
    else $error("fill count beyond record size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REC_COUNT || state_q == ST_REC_ADDR_HI || state_q == ST_REC_ADDR_LO ||
     state_q == ST_REC_DATA || state_q == ST_REC_SUM) |-> fill_q != '0)
    else $error("emitting an empty record");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REC_SUM && slot_free) |=> (fill_q == '0 && sum_q == '0))
    else $error("record state not cleared after checksum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD_HI) |-> act_q == ACT_WORD)
    else $error("high byte step without a word item");

endmodule

[sim/srec_record_scoreboard.sv]
`timescale 1ns / 1ps

module srec_record_scoreboard
  import srec_pkg::*;
#(
  parameter int unsigned RECORD_DATA_BYTES = RecordDataBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] data_value_i,
  input  logic [15:0] location_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        record_kind_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } rec_byte_t;

  // record bytes still owed by the block, oldest first
  rec_byte_t   record_bytes_due[$];

  // shadow of the record being assembled
  logic [7:0]  shadow_data [RECORD_DATA_BYTES];
  logic [15:0] shadow_base;
  int unsigned shadow_fill;
  logic        shadow_open;
  logic [7:0]  shadow_sum;
  logic [15:0] shadow_start;

  task automatic queue_byte(input kind_e kind, input logic [7:0] data, input logic last);
    rec_byte_t entry;
    entry.kind = kind;
    entry.data = data;
    entry.last = last;
    record_bytes_due.push_back(entry);
  endtask

  // close the open S1 record into count, address, data and checksum bytes
  task automatic close_s1_record();
    logic [7:0] count;
    logic [7:0] sum;
    if (!shadow_open || shadow_fill == 0) return;
    count = 8'(shadow_fill) + RecOverhead;
    sum   = shadow_sum + count;
    queue_byte(KIND_S1, count, 1'b0);
    queue_byte(KIND_S1, shadow_base[15:8], 1'b0);
    queue_byte(KIND_S1, shadow_base[7:0], 1'b0);
    for (int i = 0; i < shadow_fill; i++) queue_byte(KIND_S1, shadow_data[i], 1'b0);
    queue_byte(KIND_S1, ~sum, 1'b1);
    shadow_open = 1'b0;
    shadow_fill = 0;
    shadow_sum  = 8'd0;
  endtask

  // one data byte, opening a record at its location if none is open
  task automatic append_data_byte(input logic [7:0] data, input logic [15:0] loc);
    if (!shadow_open) begin
      shadow_open = 1'b1;
      shadow_base = loc;
      shadow_fill = 0;
      shadow_sum  = loc[15:8] + loc[7:0];
    end
    shadow_data[shadow_fill] = data;
    shadow_fill++;
    shadow_sum = shadow_sum + data;
    if (shadow_fill >= RECORD_DATA_BYTES) close_s1_record();
  endtask

  task automatic predict_record_bytes(input logic [1:0] action, input logic [15:0] data,
                                      input logic [15:0] loc);
    logic [7:0]  end_sum;
    logic [15:0] next_loc;
    next_loc = loc + 16'd1;
    case (action)
      ACT_BYTE: append_data_byte(data[7:0], loc);
      ACT_WORD: begin
        append_data_byte(data[7:0], loc);
        append_data_byte(data[15:8], next_loc);
      end
      ACT_FLUSH: close_s1_record();
      default: begin
        end_sum = EndCount + shadow_start[15:8] + shadow_start[7:0];
        queue_byte(KIND_S9, EndCount, 1'b0);
        queue_byte(KIND_S9, shadow_start[15:8], 1'b0);
        queue_byte(KIND_S9, shadow_start[7:0], 1'b0);
        queue_byte(KIND_S9, ~end_sum, 1'b1);
      end
    endcase
  endtask

  // compare one output transfer with the oldest byte owed
  task automatic check_record_byte();
    rec_byte_t want;
    if (record_bytes_due.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: unexpected output kind %0d byte %02h last %0d",
                 $realtime, record_kind_i, out_byte_i, last_i);
    end else begin
      want = record_bytes_due.pop_front();
      if (want.kind != record_kind_i || want.data != out_byte_i || want.last != last_i) begin
        fail_count_o++;
        if (fail_count_o <= 10)
          $display("%0t: mismatch: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
                   $realtime, want.kind, want.data, want.last,
                   record_kind_i, out_byte_i, last_i);
      end
    end
  endtask

  // watch the channels; output first so a result never meets its own item's prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_bytes_due.delete();
      shadow_base  = 16'd0;
      shadow_fill  = 0;
      shadow_open  = 1'b0;
      shadow_sum   = 8'd0;
      shadow_start = 16'd0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_record_byte();
      if (in_valid_i && in_ready_i) predict_record_bytes(action_i, data_value_i, location_i);
      if (cfg_we_i) shadow_start = cfg_wdata_i;
      pending_o = record_bytes_due.size();
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import srec_pkg::*;

  localparam int unsigned RecordBytes = RecordDataBytesDefault;
  localparam int unsigned SettleCycles = RecordBytes + 30;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned ItemsPerPhase = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [15:0] data_value_i;
  logic [15:0] location_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        record_kind_o;
  logic [7:0]  out_byte_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold_req = 1'b0;

  srecord_s1_record_builder_unit #(
    .RECORD_DATA_BYTES(RecordBytes)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .data_value_i (data_value_i),
    .location_i   (location_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .record_kind_o(record_kind_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

  srec_record_scoreboard #(
    .RECORD_DATA_BYTES(RecordBytes)
  ) u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .action_i     (action_i),
    .data_value_i (data_value_i),
    .location_i   (location_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .record_kind_i(record_kind_o),
    .out_byte_i   (out_byte_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin : record_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one item, idling first at random, and wait for its transfer
  task automatic send_item(input action_e action, input logic [15:0] data,
                           input logic [15:0] loc);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= action;
    data_value_i <= data;
    location_i   <= loc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // mostly data, some flushes and end records; locations lean towards the top of memory
  task automatic send_random_item();
    action_e     action;
    int unsigned pick;
    logic [15:0] loc;
    pick = $urandom_range(99);
    if (pick < 42) action = ACT_BYTE;
    else if (pick < 84) action = ACT_WORD;
    else if (pick < 94) action = ACT_FLUSH;
    else action = ACT_END;
    if ($urandom_range(9) == 0) loc = 16'hFFFF - 16'($urandom_range(3));
    else loc = 16'($urandom);
    send_item(action, 16'($urandom), loc);
  endtask

  // stop offering, let every owed byte arrive, then let the block settle
  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_start_address(input logic [15:0] value);
    wait_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 16'd0;
    in_valid_i   = 1'b0;
    action_i     = ACT_BYTE;
    data_value_i = 16'd0;
    location_i   = 16'd0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: end record at reset start address, empty flushes, short record at the top
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    send_item(ACT_END, 16'h0000, 16'h0000);
    send_item(ACT_FLUSH, 16'hFFFF, 16'hFFFF);
    send_item(ACT_BYTE, 16'hFF00, 16'hFFFF);
    send_item(ACT_WORD, 16'hFFFF, 16'h0000);
    send_item(ACT_FLUSH, 16'h0000, 16'h0000);
    send_item(ACT_FLUSH, 16'h0000, 16'h0000);

    // fill to one short of a full record, then a word across the boundary and the wrap
    for (int i = 0; i < 15; i++) send_item(ACT_WORD, 16'($urandom), 16'hFFC0);
    send_item(ACT_BYTE, 16'h005A, 16'h1234);
    send_item(ACT_WORD, 16'hA5C3, 16'hFFFF);

    // end record leaves the open record alone
    write_start_address(16'hFFFF);
    send_item(ACT_END, 16'h0000, 16'h0000);
    send_item(ACT_FLUSH, 16'h0000, 16'h0000);

    // random phases with different idling, a fresh start address for each
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_start_address(16'h0000);
          long_hold_req = 1'b1;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
          write_start_address(16'h8001);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
          write_start_address(16'($urandom));
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
          write_start_address(16'h7FFE);
        end
      endcase
      repeat (ItemsPerPhase) send_random_item();
    end

    wait_until_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
